### rtl/cpu8_alu_pkg.sv
// Package for the 8-bit ALU with flags: operation codes, queued request type.
// No dependencies.
`timescale 1ns / 1ps
package cpu8_alu_pkg;

  localparam int CmdW = 6;
  localparam int WordW = 16;
  localparam int QueueDepth = 2;

  localparam logic [CmdW-1:0] OP_ADD = 6'd0, OP_ADC = 6'd1, OP_SUB = 6'd2, OP_SBC = 6'd3,
    OP_AND = 6'd4, OP_OR = 6'd5, OP_XOR = 6'd6, OP_CP = 6'd7, OP_INC8 = 6'd8, OP_DEC8 = 6'd9,
    OP_ADD16 = 6'd10, OP_INC16 = 6'd11, OP_DEC16 = 6'd12, OP_ADDSP = 6'd13,
    OP_RLC = 6'd14, OP_RRC = 6'd15, OP_RL = 6'd16, OP_RR = 6'd17, OP_SLA = 6'd18,
    OP_SRA = 6'd19, OP_SWAP = 6'd20, OP_SRL = 6'd21, OP_BIT = 6'd22, OP_RES = 6'd23,
    OP_SET = 6'd24, OP_RLCA = 6'd25, OP_RRCA = 6'd26, OP_RLA = 6'd27, OP_RRA = 6'd28,
    OP_DAA = 6'd29, OP_CPL = 6'd30, OP_SCF = 6'd31, OP_CCF = 6'd32, OP_LDF = 6'd33;

  // Decoded request as it waits in the queue
  typedef struct packed {
    logic [CmdW-1:0]  cmd;
    logic             valid_op;
    logic [WordW-1:0] a;
    logic [WordW-1:0] b;
    logic [2:0]       k;
  } req_t;

endpackage

### rtl/cpu8_front.sv
// Front end: accepts requests, tags unused codes, holds them in a short queue.
// Depends on cpu8_alu_pkg.
`timescale 1ns / 1ps
module cpu8_front #(
  parameter int Depth = cpu8_alu_pkg::QueueDepth
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [cpu8_alu_pkg::CmdW-1:0]  command,
  input  logic [cpu8_alu_pkg::WordW-1:0] operand_a,
  input  logic [cpu8_alu_pkg::WordW-1:0] operand_b,
  input  logic [2:0]                     bit_index,
  output logic                           q_valid,
  input  logic                           q_ready,
  output cpu8_alu_pkg::req_t             q_req
);
  import cpu8_alu_pkg::*;
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  req_t             mem [Depth];
  logic [AW-1:0]    wr_ptr, rd_ptr;
  logic [AW:0]      count;
  logic             push, pop;

  assign in_ready = (count != (AW+1)'(Depth));
  assign q_valid  = (count != '0);
  assign push = in_valid && in_ready;
  assign pop  = q_valid && q_ready;
  assign q_req = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= '{cmd: command, valid_op: (command <= OP_LDF),
                       a: operand_a, b: operand_b, k: bit_index};
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == AW'(Depth-1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == AW'(Depth-1)) ? '0 : rd_ptr + 1'b1;
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end
endmodule

### rtl/cpu8_back.sv
// Back end: executes one queued request per cycle unless stalled, keeps the
// flag register, registers the result. Depends on cpu8_alu_pkg.
`timescale 1ns / 1ps
module cpu8_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_valid,
  output logic                           q_ready,
  input  cpu8_alu_pkg::req_t             q_req,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [cpu8_alu_pkg::WordW-1:0] result,
  output logic                           write_back,
  output logic                           flag_zero,
  output logic                           flag_subtract,
  output logic                           flag_half,
  output logic                           flag_carry
);
  import cpu8_alu_pkg::*;

  logic [3:0]  flags;
  logic        z, n, h, c, wb;
  logic [15:0] r;
  logic [7:0]  a8, b8, adj;
  logic [8:0]  s9;
  logic [4:0]  s5;
  logic [16:0] s17;
  logic [12:0] s13;
  logic        ci, fire;

  assign q_ready = !out_valid || out_ready;
  assign fire = q_valid && q_ready;

  always_comb begin
    a8 = q_req.a[7:0];
    b8 = q_req.b[7:0];
    z = flags[3]; n = flags[2]; h = flags[1]; c = flags[0];
    r = '0; wb = 1'b1; adj = '0; s9 = '0; s5 = '0; s17 = '0; s13 = '0;
    ci = (q_req.cmd == OP_ADC || q_req.cmd == OP_SBC) ? flags[0] : 1'b0;
    unique case (q_req.cmd)
      OP_ADD, OP_ADC: begin
        s9 = {1'b0, a8} + {1'b0, b8} + 9'(ci);
        s5 = {1'b0, a8[3:0]} + {1'b0, b8[3:0]} + 5'(ci);
        h = s5[4]; c = s9[8]; r = {8'h00, s9[7:0]}; z = (s9[7:0] == 8'h00); n = 1'b0;
      end
      OP_SUB, OP_SBC, OP_CP: begin
        s9 = {1'b0, a8} - {1'b0, b8} - 9'(ci);
        s5 = {1'b0, a8[3:0]} - {1'b0, b8[3:0]} - 5'(ci);
        h = s5[4]; c = s9[8]; z = (s9[7:0] == 8'h00); n = 1'b1;
        if (q_req.cmd == OP_CP) wb = 1'b0;
        else r = {8'h00, s9[7:0]};
      end
      OP_AND: begin r = {8'h00, a8 & b8}; z = (r == 0); n = 0; h = 1; c = 0; end
      OP_OR:  begin r = {8'h00, a8 | b8}; z = (r == 0); n = 0; h = 0; c = 0; end
      OP_XOR: begin r = {8'h00, a8 ^ b8}; z = (r == 0); n = 0; h = 0; c = 0; end
      OP_INC8: begin
        r = {8'h00, a8 + 8'd1}; z = (r == 0); n = 0; h = (r[3:0] == 4'h0);
      end
      OP_DEC8: begin
        r = {8'h00, a8 - 8'd1}; z = (r == 0); n = 1; h = (r[3:0] == 4'hF);
      end
      OP_ADD16: begin
        s17 = {1'b0, q_req.a} + {1'b0, q_req.b};
        s13 = {1'b0, q_req.a[11:0]} + {1'b0, q_req.b[11:0]};
        h = s13[12]; c = s17[16]; r = s17[15:0]; n = 0;
      end
      OP_INC16: r = q_req.a + 16'd1;
      OP_DEC16: r = q_req.a - 16'd1;
      OP_ADDSP: begin
        s9 = {1'b0, a8} + {1'b0, b8};
        s5 = {1'b0, a8[3:0]} + {1'b0, b8[3:0]};
        h = s5[4]; c = s9[8];
        r = q_req.a + {{8{b8[7]}}, b8};
        z = 0; n = 0;
      end
      OP_RLC, OP_RLCA: begin r = {8'h00, a8[6:0], a8[7]}; c = a8[7]; end
      OP_RRC, OP_RRCA: begin r = {8'h00, a8[0], a8[7:1]}; c = a8[0]; end
      OP_RL, OP_RLA:   begin r = {8'h00, a8[6:0], flags[0]}; c = a8[7]; end
      OP_RR, OP_RRA:   begin r = {8'h00, flags[0], a8[7:1]}; c = a8[0]; end
      OP_SLA:  begin r = {8'h00, a8[6:0], 1'b0}; c = a8[7]; end
      OP_SRA:  begin r = {8'h00, a8[7], a8[7:1]}; c = a8[0]; end
      OP_SWAP: begin r = {8'h00, a8[3:0], a8[7:4]}; c = 0; end
      OP_SRL:  begin r = {8'h00, 1'b0, a8[7:1]}; c = a8[0]; end
      OP_BIT:  begin z = !a8[q_req.k]; n = 0; h = 1; wb = 0; end
      OP_RES:  begin r = {8'h00, a8}; r[q_req.k] = 1'b0; end
      OP_SET:  begin r = {8'h00, a8}; r[q_req.k] = 1'b1; end
      OP_DAA: begin
        if (!flags[2]) begin
          if (flags[0] || a8 > 8'h99) begin adj[6:5] = 2'b11; c = 1; end
          if (flags[1] || a8[3:0] > 4'd9) adj[2:1] = 2'b11;
          r = {8'h00, a8 + adj};
        end else begin
          if (flags[0]) adj[6:5] = 2'b11;
          if (flags[1]) adj[2:1] = 2'b11;
          r = {8'h00, a8 - adj};
        end
        z = (r == 0); h = 0;
      end
      OP_CPL: begin r = {8'h00, ~a8}; n = 1; h = 1; end
      OP_SCF: begin n = 0; h = 0; c = 1; wb = 0; end
      OP_CCF: begin n = 0; h = 0; c = !flags[0]; wb = 0; end
      OP_LDF: begin r = {q_req.a[15:4], 4'h0}; {z, n, h, c} = q_req.a[7:4]; end
      default: wb = 1'b0;
    endcase
    if (!q_req.valid_op) begin
      r = '0; wb = 1'b0; {z, n, h, c} = flags;
    end
    if (q_req.cmd >= OP_RLC && q_req.cmd <= OP_SRL) begin
      z = (r == 0); n = 0; h = 0;
    end
    if (q_req.cmd >= OP_RLCA && q_req.cmd <= OP_RRA) begin
      z = 0; n = 0; h = 0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result <= r; write_back <= wb;
      {flag_zero, flag_subtract, flag_half, flag_carry} <= {z, n, h, c};
    end
    if (rst) begin
      flags <= '0;
      out_valid <= 1'b0;
    end else begin
      if (fire) flags <= {z, n, h, c};
      if (fire) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end
endmodule

### rtl/cpu8_alu_with_flags.sv
// 8-bit CPU ALU with Z/N/H/C flags: a two-entry request queue, an execute stage
// and an output register. Depends on cpu8_alu_pkg, cpu8_front, cpu8_back.
`timescale 1ns / 1ps
// One request per cycle sustained while out_ready keeps the output free; an
// accepted request is written to a queue slot, then the execute stage writes the
// output register and raises out_valid. The flag register lives in
// the execute stage, so each request sees the flags left by the one before it.
// Unused codes return zero, no write-back, flags kept.
module cpu8_alu_with_flags #(
  parameter int QueueDepth = cpu8_alu_pkg::QueueDepth
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [cpu8_alu_pkg::CmdW-1:0]  command,
  input  logic [cpu8_alu_pkg::WordW-1:0] operand_a,
  input  logic [cpu8_alu_pkg::WordW-1:0] operand_b,
  input  logic [2:0]                     bit_index,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [cpu8_alu_pkg::WordW-1:0] result,
  output logic                           write_back,
  output logic                           flag_zero,
  output logic                           flag_subtract,
  output logic                           flag_half,
  output logic                           flag_carry
);
  import cpu8_alu_pkg::*;

  logic q_valid, q_ready;
  req_t q_req;

  cpu8_front #(.Depth(QueueDepth)) u_front (
    .clk, .rst, .in_valid, .in_ready, .command, .operand_a, .operand_b, .bit_index,
    .q_valid, .q_ready, .q_req
  );

  cpu8_back u_back (
    .clk, .rst, .q_valid, .q_ready, .q_req, .out_valid, .out_ready, .result,
    .write_back, .flag_zero, .flag_subtract, .flag_half, .flag_carry
  );

  // No result after reset without a request behind it
  a_out_after_rst: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !out_valid)
    else $error("out_valid without request");
  // Queue head moves to output register whenever output side is free
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (q_valid && (!out_valid || out_ready)) |=> out_valid)
    else $error("queued request not executed");
  // Compare never writes back
  a_cp_wb: assert property (@(posedge clk) disable iff (rst)
    (q_valid && q_ready && q_req.cmd == OP_CP) |=> !write_back)
    else $error("cp wrote back");
endmodule

### test/tb_cpu8_alu_with_flags.sv
// Testbench for cpu8_alu_with_flags: directed and random ALU requests, with a
// flag-tracking predictor and an in-order scoreboard. Depends on cpu8_alu_pkg.
`timescale 1ns / 1ps
module tb_cpu8_alu_with_flags;
  import cpu8_alu_pkg::*;

  typedef struct packed {
    logic [15:0] res;
    logic        wb;
    logic [3:0]  zhnc;  // Z N H C
  } alu_out_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_ready;
  logic [5:0]  command = '0;
  logic [15:0] operand_a = '0;
  logic [15:0] operand_b = '0;
  logic [2:0]  bit_index = '0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [15:0] result;
  logic        write_back, flag_zero, flag_subtract, flag_half, flag_carry;

  logic [3:0]  model_flags = '0;
  alu_out_t    expected_q[$];
  int          errors = 0;
  int          hold_off = 0;     // receiver long stall request
  int          burst_mode = 1;   // 0: no receiver stalls

  cpu8_alu_with_flags DUT (.*);

  initial forever #5 clk = ~clk;

  initial begin
    #50_000_000;
    $display("cpu8_alu_with_flags test failed");
    $finish;
  end

  function automatic alu_out_t alu_predict(logic [5:0] op, logic [15:0] a,
                                           logic [15:0] b, logic [2:0] k);
    alu_out_t o;
    logic z, n, h, c, ci;
    logic [7:0] a8, b8, r8, adj;
    logic [16:0] s17;
    logic [8:0] s9;
    logic [15:0] r;
    logic wb;
    a8 = a[7:0]; b8 = b[7:0];
    {z, n, h, c} = model_flags;
    r = '0; wb = 1;
    case (op)
      OP_ADD, OP_ADC: begin
        ci = (op == OP_ADC) ? c : 1'b0;
        s9 = a8 + b8 + ci;
        h = ({1'b0, a8[3:0]} + b8[3:0] + ci) > 5'hF;
        c = s9[8]; r = s9[7:0]; z = (s9[7:0] == 0); n = 0;
      end
      OP_SUB, OP_SBC, OP_CP: begin
        ci = (op == OP_SBC) ? c : 1'b0;
        h = {1'b0, a8[3:0]} < ({1'b0, b8[3:0]} + ci);
        c = {1'b0, a8} < ({1'b0, b8} + ci);
        r8 = a8 - b8 - ci; r = r8; z = (r8 == 0); n = 1;
        if (op == OP_CP) begin r = 0; wb = 0; end
      end
      OP_AND: begin r = a8 & b8; z = (r == 0); n = 0; h = 1; c = 0; end
      OP_OR:  begin r = a8 | b8; z = (r == 0); n = 0; h = 0; c = 0; end
      OP_XOR: begin r = a8 ^ b8; z = (r == 0); n = 0; h = 0; c = 0; end
      OP_INC8: begin r8 = a8 + 1; r = r8; z = (r8 == 0); n = 0; h = (r8[3:0] == 0); end
      OP_DEC8: begin r8 = a8 - 1; r = r8; z = (r8 == 0); n = 1; h = (r8[3:0] == 4'hF); end
      OP_ADD16: begin
        h = ({1'b0, a[11:0]} + b[11:0]) >= 13'h1000;
        s17 = a + b; c = s17[16]; r = s17[15:0]; n = 0;
      end
      OP_INC16: r = a + 1;
      OP_DEC16: r = a - 1;
      OP_ADDSP: begin
        h = ({1'b0, a[3:0]} + b8[3:0]) >= 5'h10;
        s9 = a[7:0] + b8; c = s9[8];
        r = a + {{8{b8[7]}}, b8}; z = 0; n = 0;
      end
      OP_RLC, OP_RLCA: begin r = {a8[6:0], a8[7]}; c = a8[7]; end
      OP_RRC, OP_RRCA: begin r = {a8[0], a8[7:1]}; c = a8[0]; end
      OP_RL, OP_RLA:   begin r = {a8[6:0], c}; c = a8[7]; end
      OP_RR, OP_RRA:   begin r = {c, a8[7:1]}; c = a8[0]; end
      OP_SLA:  begin r = {a8[6:0], 1'b0}; c = a8[7]; end
      OP_SRA:  begin r = {a8[7], a8[7:1]}; c = a8[0]; end
      OP_SWAP: begin r = {a8[3:0], a8[7:4]}; c = 0; end
      OP_SRL:  begin r = {1'b0, a8[7:1]}; c = a8[0]; end
      OP_BIT:  begin z = ~a8[k]; n = 0; h = 1; wb = 0; end
      OP_RES:  begin r8 = a8; r8[k] = 0; r = r8; end
      OP_SET:  begin r8 = a8; r8[k] = 1; r = r8; end
      OP_DAA: begin
        adj = 0;
        if (!n) begin
          if (c || a8 > 8'h99) begin adj[6:5] = 2'b11; c = 1; end
          if (h || a8[3:0] > 9) adj[2:1] = 2'b11;
          r8 = a8 + adj;
        end else begin
          if (c) adj[6:5] = 2'b11;
          if (h) adj[2:1] = 2'b11;
          r8 = a8 - adj;
        end
        r = r8; z = (r8 == 0); h = 0;
      end
      OP_CPL: begin r = ~a8 & 8'hFF; n = 1; h = 1; end
      OP_SCF: begin n = 0; h = 0; c = 1; wb = 0; end
      OP_CCF: begin n = 0; h = 0; c = ~c; wb = 0; end
      OP_LDF: begin r = {a[15:4], 4'h0}; {z, n, h, c} = a[7:4]; end
      default: wb = 0;
    endcase
    if (op >= OP_RLC && op <= OP_SRL) begin z = (r == 0); n = 0; h = 0; end
    if (op >= OP_RLCA && op <= OP_RRA) begin z = 0; n = 0; h = 0; end
    model_flags = {z, n, h, c};
    o.res = r; o.wb = wb; o.zhnc = {z, n, h, c};
    return o;
  endfunction

  // sends one request; valid stays high so the next one can follow directly,
  // callers drop it before a gap
  task automatic send_request(logic [5:0] op, logic [15:0] a, logic [15:0] b,
                              logic [2:0] k);
    in_valid <= 1; command <= op; operand_a <= a; operand_b <= b; bit_index <= k;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_q.push_back(alu_predict(op, a, b, k));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // receiver stall pattern
  initial begin
    int cnt;
    @(negedge clk);
    forever begin
      if (hold_off > 0) begin
        out_ready <= 0;
        cnt = hold_off; hold_off = 0;
        repeat (cnt) @(negedge clk);
      end else begin
        out_ready <= (burst_mode == 0) ? 1'b1 : ($urandom_range(0, 3) != 0);
        @(negedge clk);
      end
    end
  end

  // result checker
  initial begin
    alu_out_t e;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $error("result with no request pending");
          errors++;
        end else begin
          e = expected_q.pop_front();
          if (result !== e.res) begin
            $error("result exp %h got %h", e.res, result); errors++;
          end
          if (write_back !== e.wb) begin
            $error("write_back exp %b got %b", e.wb, write_back); errors++;
          end
          if (flag_zero !== e.zhnc[3]) begin
            $error("flag_zero exp %b got %b", e.zhnc[3], flag_zero); errors++;
          end
          if (flag_subtract !== e.zhnc[2]) begin
            $error("flag_subtract exp %b got %b", e.zhnc[2], flag_subtract); errors++;
          end
          if (flag_half !== e.zhnc[1]) begin
            $error("flag_half exp %b got %b", e.zhnc[1], flag_half); errors++;
          end
          if (flag_carry !== e.zhnc[0]) begin
            $error("flag_carry exp %b got %b", e.zhnc[0], flag_carry); errors++;
          end
        end
      end
    end
  end

  task automatic test_directed();
    send_request(OP_ADD, 16'h00FF, 16'h0001, 0);
    send_request(OP_ADC, 16'h000F, 16'h0000, 0);
    send_request(OP_SBC, 16'h0000, 16'h00FF, 0);
    send_request(OP_CP, 16'h0042, 16'h0042, 0);
    send_request(OP_AND, 16'hFFFF, 16'hFFFF, 7);
    send_request(OP_OR, 16'h0000, 16'h0000, 0);
    send_request(OP_XOR, 16'h00AA, 16'h0055, 0);
    send_request(OP_INC8, 16'h00FF, 0, 0);
    send_request(OP_DEC8, 16'h0010, 0, 0);
    send_request(OP_ADD16, 16'h8FFF, 16'h7001, 0);
    send_request(OP_INC16, 16'hFFFF, 0, 0);
    send_request(OP_DEC16, 16'h0000, 0, 0);
    send_request(OP_ADDSP, 16'hFFF8, 16'h0080, 0);
    send_request(OP_ADDSP, 16'h000F, 16'h00FF, 0);
    send_request(OP_BIT, 16'h0080, 0, 7);
    send_request(OP_RES, 16'h00FF, 0, 0);
    send_request(OP_SET, 16'h0000, 0, 7);
    send_request(OP_ADD, 16'h0009, 16'h0009, 0);
    send_request(OP_DAA, 16'h0012, 0, 0);
    send_request(OP_SUB, 16'h0010, 16'h0001, 0);
    send_request(OP_DAA, 16'h000F, 0, 0);
    send_request(OP_LDF, 16'hFFFF, 0, 0);
    send_request(OP_CCF, 0, 0, 0);
    send_request(OP_SCF, 0, 0, 0);
    send_request(6'd63, 16'hFFFF, 16'hFFFF, 7);
  endtask

  task automatic test_random(int count);
    int gap;
    logic [5:0] op;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 7) == 0) begin
        gap = $urandom_range(1, 6);
        in_valid <= 0;
        repeat (gap) @(negedge clk);
      end
      op = ($urandom_range(0, 19) == 0) ? 6'($urandom_range(34, 63))
                                        : 6'($urandom_range(0, 33));
      send_request(op, 16'($urandom), 16'($urandom), 3'($urandom));
    end
  endtask

  task automatic test_backpressure();
    hold_off = 60;
    test_random(20);
    wait_drained();  // sender pauses until everything is back
    burst_mode = 0;
    test_random(200);
    burst_mode = 1;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    test_directed();
    test_backpressure();
    test_random(1350);
    wait_drained();
    repeat (10) @(negedge clk);
    if (errors == 0 && expected_q.size() == 0)
      $display("cpu8_alu_with_flags test passed");
    else
      $display("cpu8_alu_with_flags test failed");
    $finish;
  end
endmodule

### sim.f
rtl/cpu8_alu_pkg.sv
rtl/cpu8_front.sv
rtl/cpu8_back.sv
rtl/cpu8_alu_with_flags.sv
test/tb_cpu8_alu_with_flags.sv
